@@ rtl/tat_pkg.sv @@
// ----------------------------------------------------------------------------
// tat_pkg
// Shared types and constants for the timed allowlist table: opcodes, result
// status codes, controller states and the command/status bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package tat_pkg;

  // Table geometry and field widths
  localparam int TAT_ENTRIES     = 5;
  localparam int TAT_KEY_W       = 40;
  localparam int TAT_TIME_W      = 32;
  localparam int TAT_OP_W        = 2;
  localparam int TAT_STATUS_W    = 3;
  localparam int TAT_COUNT_OUT_W = 3;
  localparam int TAT_WORD_W      = TAT_KEY_W + TAT_TIME_W;

  localparam logic [TAT_TIME_W-1:0] TAT_TIMEOUT_RESET = 32'd900000;

  // Opcodes (any other code behaves as a sweep)
  localparam logic [TAT_OP_W-1:0] OP_ADD   = 2'd0;
  localparam logic [TAT_OP_W-1:0] OP_CHECK = 2'd1;
  localparam logic [TAT_OP_W-1:0] OP_SWEEP = 2'd2;

  // Result status codes
  localparam logic [TAT_STATUS_W-1:0] ST_ADDED     = 3'd0;
  localparam logic [TAT_STATUS_W-1:0] ST_REFRESHED = 3'd1;
  localparam logic [TAT_STATUS_W-1:0] ST_FULL      = 3'd2;
  localparam logic [TAT_STATUS_W-1:0] ST_MATCHED   = 3'd3;
  localparam logic [TAT_STATUS_W-1:0] ST_NOMATCH   = 3'd4;
  localparam logic [TAT_STATUS_W-1:0] ST_SWEPT     = 3'd5;

  // Controller states
  typedef enum logic [1:0] {
    TS_IDLE,
    TS_WALK,
    TS_COMMIT
  } tat_state_t;

  // Controller to datapath
  typedef struct packed {
    logic start;   // latch a new request and reset the walk
    logic walk;    // step through the stored entries
    logic commit;  // apply the final update and load the result
  } tat_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic walk_done;  // every entry issued and evaluated
    logic out_free;   // output register can take a result this cycle
  } tat_sts_t;

endpackage

`default_nettype wire

@@ rtl/timed_allowlist_table_unit.sv @@
// ----------------------------------------------------------------------------
// timed_allowlist_table_unit
// Compacting table of authorised keys with time stamps and entry aging.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the s_ channel: s_tuser carries the opcode (add or
//   refresh, expire then check, expire only), s_tdata the key and the
//   current millisecond time. Each request gives exactly one result on the
//   m_ channel: m_tuser carries the status, m_tdata the number of entries
//   in use and the number of entries expired by this request.
//   The timeout is written on the cfg_ channel while no request is in
//   flight, a rule for the user that the block itself does not enforce;
//   cfg_ready is always high. A request walks the n entries stored
//   before it one per cycle through the registered read port of the
//   entry memory, then commits once the output register is free, which
//   raises m_tvalid. One request is handled at a time; the next is taken
//   only after the previous one has committed.
//   Reset empties the table and restores the timeout to 900000 ms; the
//   memory needs no clearing since only entries below the count are read.
//   When the receiver stalls, the result stays in the output register and
//   the next request is walked but holds before its commit until the
//   register is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module timed_allowlist_table_unit
  import tat_pkg::*;
#(
  parameter int ENTRIES = TAT_ENTRIES
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // Request channel
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [71:0] s_tdata,   // [39:0] key, [71:40] now_ms
  input  wire logic [1:0]  s_tuser,   // [1:0] opcode
  // Result channel
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_tdata,   // [2:0] entries_in_use, [5:3] expired_count
  output logic [2:0]       m_tuser,   // [2:0] status
  // Timeout write channel
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [31:0] cfg_data
);

  tat_cmd_t cmd;
  tat_sts_t sts;

  logic [TAT_COUNT_OUT_W-1:0] in_use;
  logic [TAT_COUNT_OUT_W-1:0] expired;

  assign cfg_ready = 1'b1;
  assign m_tdata   = {2'b00, expired, in_use};

  tat_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  tat_dpath #(
    .ENTRIES (ENTRIES)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .in_op       (s_tuser),
    .in_key      (s_tdata[39:0]),
    .in_now      (s_tdata[71:40]),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_data    (cfg_data),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_status  (m_tuser),
    .out_in_use  (in_use),
    .out_expired (expired)
  );

  // An accepted request keeps the block busy in the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request taken while the previous one was still in flight");

  // Add never reports expired entries
  a_add_no_expiry: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == ST_ADDED || m_tuser == ST_REFRESHED || m_tuser == ST_FULL)
    |-> expired == '0)
    else $error("add reported expired entries");

  // Full is reported only with every entry in use
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == ST_FULL |-> in_use == TAT_COUNT_OUT_W'(ENTRIES))
    else $error("full reported with free entries");

  // Entry count never exceeds capacity
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (ENTRIES < 8) |-> 32'(in_use) <= 32'(ENTRIES))
    else $error("entry count above capacity");

endmodule

`default_nettype wire

@@ rtl/tat_ram.sv @@
// ----------------------------------------------------------------------------
// tat_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tat_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                      wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ rtl/tat_ctrl.sv @@
// ----------------------------------------------------------------------------
// tat_ctrl
// Controller for the timed allowlist table: takes a request, walks the
// table, then commits the update once the output register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module tat_ctrl
  import tat_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire tat_sts_t sts,
  output tat_cmd_t      cmd
);

  tat_state_t state;
  tat_state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= TS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      TS_IDLE: begin
        if (in_valid) state_next = TS_WALK;
      end
      TS_WALK: begin
        if (sts.walk_done) state_next = TS_COMMIT;
      end
      TS_COMMIT: begin
        if (sts.out_free) state_next = TS_IDLE;
      end
      default: state_next = TS_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready   = 1'b0;
    cmd        = '0;
    case (state)
      TS_IDLE: begin
        in_ready  = 1'b1;
        cmd.start = in_valid;
      end
      TS_WALK: begin
        cmd.walk = 1'b1;
      end
      TS_COMMIT: begin
        cmd.commit = sts.out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/tat_dpath.sv @@
// ----------------------------------------------------------------------------
// tat_dpath
// Datapath for the timed allowlist table: entry memory, walk counters,
// expiry and key comparison, compaction writes and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module tat_dpath
  import tat_pkg::*;
#(
  parameter int ENTRIES = TAT_ENTRIES
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire tat_cmd_t                   cmd,
  output tat_sts_t                        sts,
  input  wire logic [TAT_OP_W-1:0]        in_op,
  input  wire logic [TAT_KEY_W-1:0]       in_key,
  input  wire logic [TAT_TIME_W-1:0]      in_now,
  input  wire logic                       cfg_we,
  input  wire logic [TAT_TIME_W-1:0]      cfg_data,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [TAT_STATUS_W-1:0]         out_status,
  output logic [TAT_COUNT_OUT_W-1:0]      out_in_use,
  output logic [TAT_COUNT_OUT_W-1:0]      out_expired
);

  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(ENTRIES);

  // Request and configuration registers
  logic [TAT_OP_W-1:0]   op;
  logic [TAT_KEY_W-1:0]  key;
  logic [TAT_TIME_W-1:0] now;
  logic [TAT_TIME_W-1:0] timeout;

  // Table and walk state
  logic [CW-1:0] count;
  logic [CW-1:0] rd;
  logic [CW-1:0] wr;
  logic [CW-1:0] removed;
  logic [AW-1:0] ev_idx;
  logic [AW-1:0] hit_idx;
  logic          pend;
  logic          found;

  // Memory ports
  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [TAT_WORD_W-1:0] ram_wdata;
  logic [TAT_WORD_W-1:0] ram_rdata;

  // Decoded walk signals
  logic                  is_add;
  logic                  is_check;
  logic                  issue;
  logic                  eval;
  logic [TAT_KEY_W-1:0]  ent_key;
  logic [TAT_TIME_W-1:0] ent_stamp;
  logic [TAT_TIME_W-1:0] age;
  logic                  key_hit;
  logic                  expired;
  logic                  full;
  logic                  keep;
  logic                  add_write;
  logic [CW-1:0]         count_next;
  logic [TAT_STATUS_W-1:0] status_next;

  assign is_add    = (op == OP_ADD);
  assign is_check  = (op == OP_CHECK);
  assign issue     = cmd.walk && (rd != count);
  assign eval      = cmd.walk && pend;
  assign ent_key   = ram_rdata[TAT_WORD_W-1:TAT_TIME_W];
  assign ent_stamp = ram_rdata[TAT_TIME_W-1:0];
  assign age       = now - ent_stamp;
  assign key_hit   = (ent_key == key);
  assign expired   = (age >= timeout);
  assign full      = (count >= FULL_COUNT);
  assign keep      = eval && !is_add && !expired;
  assign add_write = cmd.commit && is_add && (found || !full);

  assign sts.walk_done = (rd == count) && !pend;
  assign sts.out_free  = !out_valid || out_ready;

  // Pick the write: compaction during the walk, add or refresh on commit
  always_comb begin
    ram_we    = keep || add_write;
    ram_waddr = wr[AW-1:0];
    ram_wdata = ram_rdata;
    if (add_write) begin
      ram_waddr = found ? hit_idx : count[AW-1:0];
      ram_wdata = {key, now};
    end
  end

  // Work out the final count and status
  always_comb begin
    count_next  = wr;
    status_next = ST_SWEPT;
    if (is_add) begin
      count_next = count;
      if (found) begin
        status_next = ST_REFRESHED;
      end else if (full) begin
        status_next = ST_FULL;
      end else begin
        status_next = ST_ADDED;
        count_next  = count + CW'(1);
      end
    end else if (is_check) begin
      status_next = found ? ST_MATCHED : ST_NOMATCH;
    end
  end

  tat_ram #(
    .WIDTH (TAT_WORD_W),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (rd[AW-1:0]),
    .rdata (ram_rdata)
  );

  // Latch the request
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      op  <= in_op;
      key <= in_key;
      now <= in_now;
    end
  end

  // Hold the timeout register
  always_ff @(posedge clk) begin
    if (rst) begin
      timeout <= TAT_TIMEOUT_RESET;
    end else if (cfg_we) begin
      timeout <= cfg_data;
    end
  end

  // Advance the walk: issue reads ahead, evaluate each entry in the cycle after its read
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else if (cmd.start) begin
      pend <= 1'b0;
    end else if (cmd.walk) begin
      pend <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      rd      <= '0;
      wr      <= '0;
      removed <= '0;
      found   <= 1'b0;
    end else begin
      if (issue) begin
        rd     <= rd + CW'(1);
        ev_idx <= rd[AW-1:0];
      end
      if (eval) begin
        if (is_add) begin
          if (key_hit && !found) begin
            found   <= 1'b1;
            hit_idx <= ev_idx;
          end
        end else if (expired) begin
          removed <= removed + CW'(1);
        end else begin
          wr <= wr + CW'(1);
          if (key_hit) found <= 1'b1;
        end
      end
    end
  end

  // Hold the entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.commit) begin
      count <= count_next;
    end
  end

  // Output register: load on commit, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_status  <= status_next;
      out_in_use  <= TAT_COUNT_OUT_W'(count_next);
      out_expired <= is_add ? '0 : TAT_COUNT_OUT_W'(removed);
    end
  end

endmodule

`default_nettype wire

@@ tb/tb_timed_allowlist_table_unit.sv @@
// ----------------------------------------------------------------------------
// tb_timed_allowlist_table_unit
// Self-checking bench for the timed allowlist table. A scoreboard object keeps
// its own copy of the key table, stamps and timeout, predicts the status and
// counts of every accepted request and checks each result in order. Requests
// come as a directed opening and then random phases under several timeouts,
// with random gaps on both streams and one long receiver hold-off.
// ----------------------------------------------------------------------------
`default_nettype none

import tat_pkg::*;

typedef struct {
  logic [TAT_STATUS_W-1:0]    status;
  logic [TAT_COUNT_OUT_W-1:0] in_use;
  logic [TAT_COUNT_OUT_W-1:0] expired;
} table_result_t;

class table_scoreboard;
  logic [TAT_KEY_W-1:0]  keys[TAT_ENTRIES];
  logic [TAT_TIME_W-1:0] stamps[TAT_ENTRIES];
  int unsigned           used;
  logic [TAT_TIME_W-1:0] timeout;
  table_result_t         awaited[$];
  int unsigned           errors;

  function new();
    used    = 0;
    timeout = TAT_TIMEOUT_RESET;
    errors  = 0;
  endfunction

  function void set_timeout(input logic [TAT_TIME_W-1:0] value);
    timeout = value;
  endfunction

  function int unsigned pending();
    return awaited.size();
  endfunction

  // Drop aged entries, closing the gaps in order; return how many went
  function int unsigned purge(input logic [TAT_TIME_W-1:0] now);
    int unsigned wr, gone;
    logic [TAT_TIME_W-1:0] age;
    wr   = 0;
    gone = 0;
    for (int rd = 0; rd < used; rd++) begin
      age = now - stamps[rd];
      if (age >= timeout) begin
        gone++;
      end else begin
        keys[wr]   = keys[rd];
        stamps[wr] = stamps[rd];
        wr++;
      end
    end
    used = wr;
    return gone;
  endfunction

  function int lookup(input logic [TAT_KEY_W-1:0] key);
    for (int i = 0; i < used; i++)
      if (keys[i] == key) return i;
    return -1;
  endfunction

  // Apply one accepted request to the table and queue its result
  function void note_request(input logic [TAT_OP_W-1:0] op, input logic [TAT_KEY_W-1:0] key,
                             input logic [TAT_TIME_W-1:0] now);
    table_result_t r;
    int hit;
    r.expired = '0;
    if (op == OP_ADD) begin
      hit = lookup(key);
      if (hit >= 0) begin
        stamps[hit] = now;
        r.status = ST_REFRESHED;
      end else if (used >= TAT_ENTRIES) begin
        r.status = ST_FULL;
      end else begin
        keys[used]   = key;
        stamps[used] = now;
        used++;
        r.status = ST_ADDED;
      end
    end else if (op == OP_CHECK) begin
      r.expired = TAT_COUNT_OUT_W'(purge(now));
      r.status  = (lookup(key) >= 0) ? ST_MATCHED : ST_NOMATCH;
    end else begin
      r.expired = TAT_COUNT_OUT_W'(purge(now));
      r.status  = ST_SWEPT;
    end
    r.in_use = TAT_COUNT_OUT_W'(used);
    awaited.push_back(r);
  endfunction

  // Compare one result with the oldest prediction
  function void check_result(input logic [TAT_STATUS_W-1:0] status,
                             input logic [TAT_COUNT_OUT_W-1:0] in_use,
                             input logic [TAT_COUNT_OUT_W-1:0] expired);
    table_result_t e;
    if (awaited.size() == 0) begin
      $error("result with nothing pending: status %0d in_use %0d expired %0d",
             status, in_use, expired);
      errors++;
      return;
    end
    e = awaited.pop_front();
    if (status !== e.status) begin
      $error("status: expected %0d, got %0d", e.status, status);
      errors++;
    end
    if (in_use !== e.in_use) begin
      $error("entries_in_use: expected %0d, got %0d", e.in_use, in_use);
      errors++;
    end
    if (expired !== e.expired) begin
      $error("expired_count: expected %0d, got %0d", e.expired, expired);
      errors++;
    end
  endfunction
endclass

module tb_timed_allowlist_table_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [TAT_OP_W-1:0]   OP_SPARE    = 2'd3;  // unused code, acts as sweep
  localparam logic [TAT_KEY_W-1:0]  KEY_ONES    = 40'hFF_FFFF_FFFF;
  localparam logic [TAT_KEY_W-1:0]  KEY_TOP     = 40'd999999999999;
  localparam logic [TAT_TIME_W-1:0] TIME_ONES   = 32'hFFFF_FFFF;
  localparam int unsigned           IDLE_LIMIT  = 3000;
  localparam int unsigned           HOLD_AT     = 300;
  localparam int unsigned           HOLD_CYCLES = 250;
  localparam int unsigned           SETTLE      = TAT_ENTRIES + 8;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [71:0] s_tdata   = '0;   // [39:0] key, [71:40] now_ms
  logic [1:0]  s_tuser   = '0;   // [1:0] opcode
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [7:0]  m_tdata;          // [2:0] entries_in_use, [5:3] expired_count
  logic [2:0]  m_tuser;          // [2:0] status
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_data  = '0;

  table_scoreboard       tbl;
  logic [TAT_KEY_W-1:0]  key_pool[8];
  logic [TAT_TIME_W-1:0] wall;
  int unsigned           send_calm;
  int unsigned           idle_cycles = 0;

  timed_allowlist_table_unit uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Draw a wait, with occasional stretches of back-to-back traffic
  function automatic int unsigned pick_gap(inout int unsigned calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(24, 0) == 0) begin
      calm = $urandom_range(40, 10);
      return 0;
    end
    return $urandom_range(14, 0);
  endfunction

  // Offer one request and hold it until taken
  task automatic send_request(input logic [TAT_OP_W-1:0] op, input logic [TAT_KEY_W-1:0] key,
                              input logic [TAT_TIME_W-1:0] now);
    int unsigned gap;
    gap = pick_gap(send_calm);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {now, key};
    do @(posedge clk); while (!s_tready);
    tbl.note_request(op, key, now);
  endtask

  // Wait for the table to drain, then write a new timeout
  task automatic write_timeout(input logic [TAT_TIME_W-1:0] value);
    while (tbl.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    tbl.set_timeout(value);
  endtask

  // Refill the key pool: edge values plus random keys, some of them small
  task automatic refill_keys();
    logic [63:0] r;
    key_pool[0] = '0;
    key_pool[1] = KEY_ONES;
    key_pool[2] = KEY_TOP;
    for (int i = 3; i < 8; i++) begin
      r = {$urandom, $urandom};
      key_pool[i] = (i < 5) ? TAT_KEY_W'($urandom_range(99, 0)) : r[TAT_KEY_W-1:0];
    end
  endtask

  // Random requests on a mostly advancing clock, mostly pooled keys
  task automatic random_phase(input int unsigned count, input int unsigned step_max);
    logic [TAT_OP_W-1:0]   op;
    logic [TAT_KEY_W-1:0]  key;
    logic [TAT_TIME_W-1:0] now;
    logic [63:0]           r;
    int unsigned           pick;
    refill_keys();
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99, 0);
      if (pick < 45)      op = OP_ADD;
      else if (pick < 85) op = OP_CHECK;
      else if (pick < 97) op = OP_SWEEP;
      else                op = OP_SPARE;
      if ($urandom_range(9, 0) == 0) begin
        r   = {$urandom, $urandom};
        key = r[TAT_KEY_W-1:0];
      end else begin
        key = key_pool[$urandom_range(7, 0)];
      end
      if ($urandom_range(19, 0) == 0) begin
        now = $urandom;
      end else begin
        wall = wall + $urandom_range(step_max, 0);
        now  = wall;
      end
      send_request(op, key, now);
    end
    s_tvalid <= 1'b0;
  endtask

  // Count cycles without any handshake and stop a hung run
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // Result side: random stalls and one long hold-off to back up the block
  initial begin : result_side
    int unsigned gap, calm, got;
    calm = 0;
    got  = 0;
    while (rst) @(posedge clk);
    forever begin
      gap = (got == HOLD_AT) ? HOLD_CYCLES : pick_gap(calm);
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      tbl.check_result(m_tuser, m_tdata[2:0], m_tdata[5:3]);
      got++;
    end
  end

  initial begin : request_side
    tbl         = new();
    send_calm   = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: fill, refresh, full, refresh when full, check, expiry, wrap
    send_request(OP_ADD,   '0,       32'd0);
    send_request(OP_ADD,   KEY_ONES, 32'd100);
    send_request(OP_ADD,   KEY_TOP,  32'd200);
    send_request(OP_ADD,   '0,       32'd300);
    send_request(OP_ADD,   40'd17,   32'd400);
    send_request(OP_ADD,   40'd18,   32'd500);
    send_request(OP_ADD,   40'd19,   32'd600);
    send_request(OP_ADD,   KEY_ONES, 32'd700);
    send_request(OP_CHECK, '0,       32'd1000);
    send_request(OP_CHECK, 40'd19,   32'd1000);
    send_request(OP_SWEEP, '0,       32'd900300);
    send_request(OP_CHECK, KEY_ONES, 32'd900600);
    send_request(OP_SPARE, KEY_ONES, TIME_ONES);
    send_request(OP_CHECK, '0,       32'd0);
    send_request(OP_ADD,   KEY_ONES, TIME_ONES);
    send_request(OP_ADD,   '0,       32'hFFFF_FFF0);
    send_request(OP_CHECK, KEY_ONES, 32'd5);
    send_request(OP_SPARE, '0,       32'd899990);
    send_request(OP_CHECK, '0,       32'd899991);
    s_tvalid <= 1'b0;

    // Random phases under several timeouts, extremes first
    wall = 32'd1000000;
    random_phase(250, 200000);
    write_timeout(32'd1);
    random_phase(200, 2);
    write_timeout(TIME_ONES);
    random_phase(200, 500000);
    write_timeout(32'd0);
    random_phase(150, 100);
    write_timeout(32'd600);
    wall = 32'hFFFF_FF00;
    random_phase(300, 300);
    for (int p = 0; p < 3; p++) begin
      write_timeout($urandom_range(5000, 50));
      random_phase(300, tbl.timeout / 2 + 1);
    end
    write_timeout(TAT_TIMEOUT_RESET);
    random_phase(200, 250000);

    // Drain and let the block settle before judging
    while (tbl.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (tbl.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire
